// ----- hdl/pbch_pkg.sv -----
`timescale 1ns / 1ps

package pbch_pkg;

  localparam int WORD_W      = 32;
  localparam int MSG_W       = 21;
  localparam int REM_W       = 10;
  localparam int NPOS        = 31;
  localparam int TAB_DEPTH   = 1 << REM_W;
  localparam int POS_W       = 5;
  localparam int FLIP_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 40;

  // x^10 reduced by the generator 0x769
  localparam logic [REM_W-1:0] GEN_LOW = 10'h369;

  typedef logic [NPOS-1:0][REM_W-1:0] pos_tab_t;

  typedef enum logic [1:0] {
    K_NONE   = 2'd0,
    K_SINGLE = 2'd1,
    K_DOUBLE = 2'd2
  } corr_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_CLEAN     = 2'd0,
    ST_CORRECTED = 2'd1,
    ST_UNCORR    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    FILL_CLEAR = 2'd0,
    FILL_PAIRS = 2'd1,
    FILL_DONE  = 2'd2
  } fill_state_t;

  typedef struct packed {
    corr_kind_t       kind;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
  } syn_entry_t;

  localparam int ENTRY_W = $bits(syn_entry_t);

  typedef struct packed {
    logic             we;
    logic [REM_W-1:0] addr;
    syn_entry_t       data;
  } tab_wr_t;

  // remainder of x^k modulo the generator, k = 0..30
  function automatic pos_tab_t gen_pos_table();
    pos_tab_t         tab;
    logic [REM_W-1:0] cur;
    cur = 10'h001;
    for (int k = 0; k < NPOS; k++) begin
      tab[k] = cur;
      cur = {cur[REM_W-2:0], 1'b0} ^ (cur[REM_W-1] ? GEN_LOW : '0);
    end
    return tab;
  endfunction

  localparam pos_tab_t POS_REM = gen_pos_table();

endpackage

// ----- hdl/pbch_ram.sv -----
`timescale 1ns / 1ps

module pbch_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/pbch_fill.sv -----
`timescale 1ns / 1ps

module pbch_fill (
  input  logic             clk,
  input  logic             rst_n,
  output pbch_pkg::tab_wr_t wr_o,
  output logic             done_o
);

  import pbch_pkg::*;

  fill_state_t      state_r, state_nxt;
  logic [REM_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [POS_W-1:0] i_r, i_nxt;
  logic [POS_W-1:0] j_r, j_nxt;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(NPOS - 1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FILL_CLEAR: if (clr_cnt_r == REM_W'(TAB_DEPTH - 1)) state_nxt = FILL_PAIRS;
      FILL_PAIRS: if (i_r == LAST_POS && j_r == LAST_POS) state_nxt = FILL_DONE;
      FILL_DONE:  state_nxt = FILL_DONE;
      default:    state_nxt = FILL_CLEAR;
    endcase
  end

  // walk i over 0..30 and j over i..30; j equal to i marks a single-bit entry
  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    if (state_r == FILL_CLEAR) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
    end else if (state_r == FILL_PAIRS) begin
      if (j_r == LAST_POS) begin
        i_nxt = i_r + 1'b1;
        j_nxt = i_r + 1'b1;
      end else begin
        j_nxt = j_r + 1'b1;
      end
    end
  end

  always_comb begin
    wr_o      = '0;
    wr_o.data = '{kind: K_NONE, lo: '0, hi: '0};
    done_o    = 1'b0;
    unique case (state_r)
      FILL_CLEAR: begin
        wr_o.we   = 1'b1;
        wr_o.addr = clr_cnt_r;
      end
      FILL_PAIRS: begin
        wr_o.we      = 1'b1;
        wr_o.data.lo = i_r;
        wr_o.data.hi = j_r;
        if (i_r == j_r) begin
          wr_o.addr      = POS_REM[i_r];
          wr_o.data.kind = K_SINGLE;
        end else begin
          wr_o.addr      = POS_REM[i_r] ^ POS_REM[j_r];
          wr_o.data.kind = K_DOUBLE;
        end
      end
      FILL_DONE: done_o = 1'b1;
      default:   done_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= FILL_CLEAR;
      clr_cnt_r <= '0;
      i_r       <= '0;
      j_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      i_r       <= i_nxt;
      j_r       <= j_nxt;
    end
  end

endmodule

// ----- hdl/pocsag_bch_codec_top.sv -----
// POCSAG BCH(31,21) codec with even parity. Each input item either encodes 21 message
// bits into a 32-bit paging codeword (in_tuser low) or corrects a received codeword
// (in_tuser high); every item gives exactly one result item. Corrections of one bit
// (parity failing) or two bits (parity passing) in bits 31..1 are looked up by syndrome
// in a 1024-entry table RAM. After reset the block builds that table and holds in_tready
// low until it is built (first clearing the RAM, then writing the single and double
// error patterns). From then on it takes one item per cycle unless stalled by out_tready;
// an item passes through the input stage and the table RAM's registered read, then the
// output register, which lets the next item enter while a result waits on out_tready.
`timescale 1ns / 1ps

module pocsag_bch_codec_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [pbch_pkg::IN_TDATA_W-1:0]  in_tdata,   // message_bits, received_word, pad
  input  logic                             in_tuser,   // req_type
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pbch_pkg::OUT_TDATA_W-1:0] out_tdata,  // result_word, flipped_bits, pad
  output logic [pbch_pkg::STATUS_W-1:0]    out_tuser   // status
);

  import pbch_pkg::*;

  tab_wr_t          tab_wr;
  logic             tab_ready;
  syn_entry_t       entry;
  logic [ENTRY_W-1:0] entry_raw;

  logic [MSG_W-1:0]  msg;
  logic [WORD_W-1:0] rx;
  logic [REM_W-1:0]  rx_rem;
  logic [REM_W-1:0]  enc_rem;
  logic [WORD_W-1:0] enc_word;
  logic              in_acc;
  logic              adv_out;
  logic              s1_move;

  logic              s1_valid_r;
  logic              s1_req_r;
  logic [WORD_W-1:0] s1_word_r;
  logic              s1_rem_zero_r;
  logic              s1_par_r;

  logic [WORD_W-1:0] flip_mask;
  status_t           st;
  logic [FLIP_W-1:0] nflip;

  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  status_t           out_status_r;
  logic [FLIP_W-1:0] out_flips_r;

  pbch_fill u_fill (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_o   (tab_wr),
    .done_o (tab_ready)
  );

  pbch_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TAB_DEPTH)
  ) u_tab (
    .clk   (clk),
    .we    (tab_wr.we),
    .waddr (tab_wr.addr),
    .wdata (tab_wr.data),
    .re    (in_acc),
    .raddr (rx_rem),
    .rdata (entry_raw)
  );

  assign entry = syn_entry_t'(entry_raw);

  assign msg = in_tdata[MSG_W-1:0];
  assign rx  = in_tdata[MSG_W+WORD_W-1:MSG_W];

  // syndrome and check bits as fixed XOR networks over the per-bit remainders
  always_comb begin
    rx_rem  = '0;
    enc_rem = '0;
    for (int k = 0; k < NPOS; k++) begin
      if (rx[k+1]) rx_rem = rx_rem ^ POS_REM[k];
    end
    for (int m = 0; m < MSG_W; m++) begin
      if (msg[m]) enc_rem = enc_rem ^ POS_REM[m+REM_W];
    end
    enc_word = {msg, enc_rem, ^{msg, enc_rem}};
  end

  assign adv_out   = !out_valid_r || out_tready;
  assign in_tready = tab_ready && (!s1_valid_r || adv_out);
  assign in_acc    = in_tvalid && in_tready;
  assign s1_move   = s1_valid_r && adv_out;

  always_comb begin
    flip_mask = '0;
    st        = ST_CLEAN;
    nflip     = '0;
    priority if (!s1_req_r) begin
      st = ST_CLEAN;
    end else if (s1_par_r) begin
      if (!s1_rem_zero_r && entry.kind == K_SINGLE) begin
        flip_mask = WORD_W'(1) << ({1'b0, entry.lo} + 6'd1);
        st        = ST_CORRECTED;
        nflip     = 2'd1;
      end else begin
        st = ST_UNCORR;
      end
    end else if (!s1_rem_zero_r) begin
      if (entry.kind == K_DOUBLE) begin
        flip_mask = (WORD_W'(1) << ({1'b0, entry.lo} + 6'd1))
                  | (WORD_W'(1) << ({1'b0, entry.hi} + 6'd1));
        st        = ST_CORRECTED;
        nflip     = 2'd2;
      end else begin
        st = ST_UNCORR;
      end
    end else begin
      st = ST_CLEAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r      <= in_tuser;
      s1_word_r     <= in_tuser ? rx : enc_word;
      s1_rem_zero_r <= (rx_rem == '0);
      s1_par_r      <= ^rx;
    end
    if (s1_move) begin
      out_word_r   <= s1_word_r ^ flip_mask;
      out_status_r <= st;
      out_flips_r  <= nflip;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - WORD_W - FLIP_W){1'b0}}, out_flips_r, out_word_r};
  assign out_tuser  = out_status_r;

endmodule

// ----- hdl/pbch_checker.sv -----
`timescale 1ns / 1ps

module pbch_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [pbch_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [pbch_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [pbch_pkg::STATUS_W-1:0]    out_tuser
);

  import pbch_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_corr_flips: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_CORRECTED |-> out_tdata[33:32] != 2'd0)
    else $error("corrected item reports no flipped bits");

  a_no_flips: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_CORRECTED |-> out_tdata[33:32] == 2'd0)
    else $error("flipped bits reported without correction");

  // encoded, clean and corrected words all carry even parity
  a_even_par: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_UNCORR |-> ^out_tdata[31:0] == 1'b0)
    else $error("result word has odd parity");

endmodule

bind pocsag_bch_codec_top pbch_checker u_pbch_checker (.*);

// ----- tb/tb_pocsag_bch_codec_top.sv -----
`timescale 1ns / 1ps

module tb_pocsag_bch_codec_top;
  import pbch_pkg::*;

  localparam logic        REQ_ENCODE   = 1'b0;
  localparam logic        REQ_CORRECT  = 1'b1;
  localparam logic [10:0] GEN_POLY     = 11'h769;
  localparam int          N_RANDOM     = 1300;
  localparam int          STALL_LIMIT  = 8000;
  localparam int          DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    status_t           status;
    logic [FLIP_W-1:0] flips;
  } codec_result_t;

  class codeword_checker;
    codec_result_t    expected_q[$];
    logic [REM_W-1:0] bit_rem[NPOS];
    int n_errors, n_checked, n_encoded, n_clean, n_single, n_double, n_uncorr;

    function new();
      for (int k = 0; k < NPOS; k++) bit_rem[k] = remainder_of(NPOS'(1) << k);
    endfunction

    function logic [REM_W-1:0] remainder_of(logic [NPOS-1:0] v);
      for (int i = MSG_W-1; i >= 0; i--) begin
        if (v[i+REM_W]) v ^= NPOS'(GEN_POLY) << i;
      end
      return v[REM_W-1:0];
    endfunction

    function logic [WORD_W-1:0] encode_word(logic [MSG_W-1:0] msg);
      logic [WORD_W-1:0] w;
      w = {msg, remainder_of({msg, REM_W'(0)}), 1'b0};
      w[0] = ^w;
      return w;
    endfunction

    function codec_result_t predict_result(logic req, logic [MSG_W-1:0] msg,
                                           logic [WORD_W-1:0] rxw);
      codec_result_t    r;
      logic [REM_W-1:0] rem;
      logic             par_fail;
      logic             found;
      r.flips  = '0;
      r.status = ST_CLEAN;
      if (req == REQ_ENCODE) begin
        r.word = encode_word(msg);
        return r;
      end
      r.word   = rxw;
      rem      = remainder_of(rxw[WORD_W-1:1]);
      par_fail = ^rxw;
      if (rem == '0 && !par_fail) return r;
      found = 1'b0;
      // parity failing points at one bit, parity passing at a pair
      if (par_fail) begin
        for (int i = 0; i < NPOS && !found; i++) begin
          if (bit_rem[i] == rem) begin
            r.word[i+1] = ~r.word[i+1];
            r.flips     = 2'd1;
            found       = 1'b1;
          end
        end
      end else begin
        for (int i = 0; i < NPOS && !found; i++) begin
          for (int j = i + 1; j < NPOS && !found; j++) begin
            if ((bit_rem[i] ^ bit_rem[j]) == rem) begin
              r.word[i+1] = ~r.word[i+1];
              r.word[j+1] = ~r.word[j+1];
              r.flips     = 2'd2;
              found       = 1'b1;
            end
          end
        end
      end
      r.status = found ? ST_CORRECTED : ST_UNCORR;
      return r;
    endfunction

    function void note_input(logic req, logic [MSG_W-1:0] msg, logic [WORD_W-1:0] rxw);
      codec_result_t r;
      r = predict_result(req, msg, rxw);
      expected_q.push_back(r);
      if (req == REQ_ENCODE) n_encoded++;
      else if (r.status == ST_CLEAN) n_clean++;
      else if (r.status == ST_UNCORR) n_uncorr++;
      else if (r.flips == 2'd1) n_single++;
      else n_double++;
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      n_errors++;
    endtask

    task check_result(logic [WORD_W-1:0] word, logic [STATUS_W-1:0] status,
                      logic [FLIP_W-1:0] flips);
      codec_result_t e;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected item word %h", word));
        return;
      end
      e = expected_q.pop_front();
      n_checked++;
      if (word !== e.word)
        report_mismatch($sformatf("word %h, expected %h", word, e.word));
      if (status !== e.status)
        report_mismatch($sformatf("status %0d, expected %0d (word %h)", status, e.status,
                                  e.word));
      if (flips !== e.flips)
        report_mismatch($sformatf("flipped bits %0d, expected %0d (word %h)", flips,
                                  e.flips, e.word));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;
  logic                   steady     = 1'b0;
  int                     quiet_cycles = 0;

  codeword_checker codec_check;

  pocsag_bch_codec_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready)
      codec_check.check_result(out_tdata[WORD_W-1:0], out_tuser,
                               out_tdata[WORD_W+FLIP_W-1:WORD_W]);
  end

  // count cycles in which no item moves on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no item moved for %0d cycles", STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic req, input logic [MSG_W-1:0] msg,
                           input logic [WORD_W-1:0] rxw);
    if (!steady && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= IN_TDATA_W'({rxw, msg});
    do @(posedge clk); while (in_tready !== 1'b1);
    codec_check.note_input(req, msg, rxw);
  endtask

  function automatic logic [WORD_W-1:0] flip_bits(logic [WORD_W-1:0] w, int n, int lo);
    logic [WORD_W-1:0] mask;
    int                k;
    mask = '0;
    while ($countones(mask) < n) begin
      k = $urandom_range(WORD_W-1, lo);
      mask[k] = 1'b1;
    end
    return w ^ mask;
  endfunction

  initial begin : stimulus
    logic [MSG_W-1:0]  msg;
    logic [WORD_W-1:0] cw;
    int                sel;
    codec_check = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // data extremes, with the unused field set at random
    send_item(REQ_ENCODE, '0, $urandom());
    send_item(REQ_ENCODE, '1, $urandom());
    send_item(REQ_ENCODE, 21'h155555, $urandom());
    send_item(REQ_ENCODE, 21'h0AAAAA, $urandom());
    send_item(REQ_ENCODE, 21'h000001, $urandom());
    send_item(REQ_ENCODE, 21'h100000, $urandom());
    cw = codec_check.encode_word(21'h12345);
    send_item(REQ_CORRECT, MSG_W'($urandom()), cw);
    send_item(REQ_CORRECT, MSG_W'($urandom()), '0);
    send_item(REQ_CORRECT, MSG_W'($urandom()), '1);
    send_item(REQ_CORRECT, MSG_W'($urandom()), 32'h5555_5555);
    // single errors at both ends of the covered range
    send_item(REQ_CORRECT, MSG_W'($urandom()), cw ^ 32'h8000_0000);
    send_item(REQ_CORRECT, MSG_W'($urandom()), cw ^ 32'h0000_0002);
    // double errors
    send_item(REQ_CORRECT, MSG_W'($urandom()), cw ^ 32'h8000_0002);
    send_item(REQ_CORRECT, MSG_W'($urandom()), cw ^ 32'h4000_0004);
    send_item(REQ_CORRECT, MSG_W'($urandom()), cw ^ 32'h0000_0006);
    // parity bit alone is reported uncorrectable
    send_item(REQ_CORRECT, MSG_W'($urandom()), cw ^ 32'h0000_0001);
    send_item(REQ_CORRECT, MSG_W'($urandom()), cw ^ 32'h0000_0021);
    send_item(REQ_CORRECT, MSG_W'($urandom()), cw ^ 32'h8000_0003);
    send_item(REQ_CORRECT, MSG_W'($urandom()), cw ^ 32'h0F00_0000);
    send_item(REQ_CORRECT, MSG_W'($urandom()), $urandom());

    for (int n = 0; n < N_RANDOM; n++) begin
      steady <= (n >= 500 && n < 800);
      msg = MSG_W'($urandom());
      cw  = codec_check.encode_word(msg);
      sel = $urandom_range(99);
      if (sel < 20)      send_item(REQ_ENCODE, msg, $urandom());
      else if (sel < 32) send_item(REQ_CORRECT, MSG_W'($urandom()), cw);
      else if (sel < 52) send_item(REQ_CORRECT, MSG_W'($urandom()), flip_bits(cw, 1, 1));
      else if (sel < 72) send_item(REQ_CORRECT, MSG_W'($urandom()), flip_bits(cw, 2, 1));
      else if (sel < 76) send_item(REQ_CORRECT, MSG_W'($urandom()), cw ^ 32'h1);
      else if (sel < 90)
        send_item(REQ_CORRECT, MSG_W'($urandom()), flip_bits(cw, $urandom_range(5, 3), 0));
      else               send_item(REQ_CORRECT, MSG_W'($urandom()), $urandom());
    end
    in_tvalid <= 1'b0;
    steady    <= 1'b0;

    while (codec_check.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d results checked: %0d encodes, %0d clean words, %0d single and %0d double",
             codec_check.n_checked, codec_check.n_encoded, codec_check.n_clean,
             codec_check.n_single, codec_check.n_double);
    $display("corrections, %0d uncorrectable words; %0d mismatches",
             codec_check.n_uncorr, codec_check.n_errors);
    if (codec_check.n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/pbch_pkg.sv
hdl/pbch_ram.sv
hdl/pbch_fill.sv
hdl/pocsag_bch_codec_top.sv
hdl/pbch_checker.sv
tb/tb_pocsag_bch_codec_top.sv
